/* sv/cmg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmg_pkg;

  // Display size used for clipping.
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 160;

  // Decoupling queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Point coordinates: 16-bit signed center plus a 16-bit offset, without wrap.
  localparam int COORD_W = 18;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_ADVANCE,
    JOB_IDLE
  } job_kind_t;

  // Index of the final point of each kind of job.
  localparam logic [2:0] START_LAST   = 3'd3;
  localparam logic [2:0] ADVANCE_LAST = 3'd7;
  localparam logic [2:0] IDLE_LAST    = 3'd0;

  typedef struct packed {
    job_kind_t           kind;
    logic signed [15:0]  cx;
    logic signed [15:0]  cy;
    logic [15:0]         ox;
    logic [15:0]         oy;
    logic [15:0]         color;
    logic                done;
  } job_t;

  // The four axis points of a start are mirror codes 0, 2, 4 and 5 with x = 0, y = r.
  function automatic logic [2:0] start_mirror(input logic [2:0] k);
    logic [2:0] m;
    unique case (k)
      3'd0:    m = 3'd0;
      3'd1:    m = 3'd2;
      3'd2:    m = 3'd4;
      default: m = 3'd5;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/cmg_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cmg_cmd_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [13:0]        radius;
  logic [15:0]        pixel_color;

  modport source (output valid, opcode, center_x, center_y, radius, pixel_color,
                  input ready);
  modport sink (input valid, opcode, center_x, center_y, radius, pixel_color,
                output ready);
endinterface

`default_nettype wire

/* sv/cmg_pt_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cmg_pt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  point_x;
  logic [7:0]  point_y;
  logic [15:0] point_color;
  logic        on_screen;
  logic        last_of_item;
  logic        circle_done;

  modport source (output valid, point_x, point_y, point_color, on_screen,
                  last_of_item, circle_done, input ready);
  modport sink (input valid, point_x, point_y, point_color, on_screen,
                last_of_item, circle_done, output ready);
endinterface

`default_nettype wire

/* sv/cmg_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmg_front
  import cmg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cmg_cmd_if.sink   cmd,
  input  logic      q_full,
  output logic      push,
  output job_t      job
);

  logic signed [15:0] center_col;
  logic signed [15:0] center_row;
  logic [15:0]        step_x;
  logic [15:0]        step_y;
  logic signed [16:0] decision;
  logic signed [16:0] delta_x;
  logic signed [16:0] delta_y;
  logic [15:0]        held_color;
  logic               active;

  logic               take_y;
  logic [15:0]        y_adv;
  logic [15:0]        x_adv;
  logic signed [16:0] dy_adv;
  logic signed [16:0] dx_adv;
  logic signed [16:0] dec_mid;
  logic signed [16:0] dec_adv;
  logic               adv_done;
  logic signed [16:0] dec_start;
  logic signed [16:0] dy_start;
  logic               start_done;

  // One midpoint iteration.
  always_comb begin
    take_y   = !decision[16];
    y_adv    = step_y - {15'd0, take_y};
    dy_adv   = take_y ? (delta_y + 17'sd2) : delta_y;
    dec_mid  = take_y ? (decision + dy_adv) : decision;
    x_adv    = step_x + 16'd1;
    dx_adv   = delta_x + 17'sd2;
    dec_adv  = dec_mid + dx_adv;
    adv_done = !(x_adv < y_adv);
  end

  always_comb begin
    dec_start  = 17'sd1 - $signed({3'b000, cmd.radius});
    dy_start   = -$signed({2'b00, cmd.radius, 1'b0});
    start_done = (cmd.radius == 14'd0);
  end

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  always_comb begin
    job = '0;
    if (opcode_t'(cmd.opcode) == OP_START) begin
      job.kind  = JOB_START;
      job.cx    = cmd.center_x;
      job.cy    = cmd.center_y;
      job.ox    = 16'd0;
      job.oy    = {2'b00, cmd.radius};
      job.color = cmd.pixel_color;
      job.done  = start_done;
    end else if (active) begin
      job.kind  = JOB_ADVANCE;
      job.cx    = center_col;
      job.cy    = center_row;
      job.ox    = x_adv;
      job.oy    = y_adv;
      job.color = held_color;
      job.done  = adv_done;
    end else begin
      job.kind  = JOB_IDLE;
      job.cx    = center_col;
      job.cy    = center_row;
      job.ox    = step_x;
      job.oy    = step_y;
      job.color = held_color;
      job.done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      step_x     <= '0;
      step_y     <= '0;
      decision   <= '0;
      delta_x    <= 17'sd1;
      delta_y    <= '0;
      held_color <= '0;
      active     <= 1'b0;
    end else if (push) begin
      unique case (opcode_t'(cmd.opcode))
        OP_START: begin
          center_col <= cmd.center_x;
          center_row <= cmd.center_y;
          held_color <= cmd.pixel_color;
          step_x     <= 16'd0;
          step_y     <= {2'b00, cmd.radius};
          decision   <= dec_start;
          delta_x    <= 17'sd1;
          delta_y    <= dy_start;
          active     <= !start_done;
        end
        OP_ADVANCE: begin
          if (active) begin
            step_x   <= x_adv;
            step_y   <= y_adv;
            decision <= dec_adv;
            delta_x  <= dx_adv;
            delta_y  <= dy_adv;
            active   <= !adv_done;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/cmg_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmg_queue
  import cmg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/cmg_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmg_back
  import cmg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     job,
  input  logic     empty,
  output logic     pop,
  cmg_pt_if.source pts
);

  logic [2:0]               k;
  logic [2:0]               k_next;
  logic [2:0]               last_k;
  logic [2:0]               m;
  logic                     load;
  logic                     emit;
  logic [15:0]              a;
  logic [15:0]              b;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                     on;

  always_comb begin
    unique case (job.kind)
      JOB_START:   last_k = START_LAST;
      JOB_ADVANCE: last_k = ADVANCE_LAST;
      default:     last_k = IDLE_LAST;
    endcase
  end

  assign load = !pts.valid || pts.ready;
  assign emit = !empty && load;
  assign pop  = emit && (k == last_k);

  always_comb begin
    if (!emit) begin
      k_next = k;
    end else if (k == last_k) begin
      k_next = 3'd0;
    end else begin
      k_next = k + 3'd1;
    end
  end

  // Mirror code: bit 2 swaps the offsets, bit 0 negates the column term,
  // bit 1 negates the row term.
  always_comb begin
    m  = (job.kind == JOB_START) ? start_mirror(k) : k;
    a  = m[2] ? job.oy : job.ox;
    b  = m[2] ? job.ox : job.oy;
    px = COORD_W'(job.cx) + (m[0] ? -$signed({2'b00, a}) : $signed({2'b00, a}));
    py = COORD_W'(job.cy) + (m[1] ? -$signed({2'b00, b}) : $signed({2'b00, b}));
    on = (job.kind != JOB_IDLE)
         && !px[COORD_W-1] && (px[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH))
         && !py[COORD_W-1] && (py[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      pts.valid <= 1'b0;
    end else begin
      k <= k_next;
      if (load) begin
        pts.valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pts.point_x      <= on ? px[7:0] : 8'd0;
      pts.point_y      <= on ? py[7:0] : 8'd0;
      pts.point_color  <= job.color;
      pts.on_screen    <= on;
      pts.last_of_item <= (k == last_k);
      pts.circle_done  <= job.done;
    end
  end

endmodule

`default_nettype wire

/* sv/midpoint_circle_point_generator.sv */
// Midpoint circle point generator with screen clipping.
// The cmd channel takes requests: opcode 0 starts a circle from center_x,
// center_y, radius and pixel_color; opcode 1 runs one midpoint iteration.
// The pts channel delivers one point per transfer, clipped to a 128 by 160
// display, with last_of_item marking the final point of a request and
// circle_done set once the octant walk has finished.
// A start yields four axis points, an advance yields eight mirrored points,
// and an advance with no circle in progress yields one off-screen point.
// An accepted request is first written to the queue, and its first point is
// then registered in the output register. The output register emits one point
// per cycle while a job waits and the receiver is not holding ready low, and
// the front end computes each iteration combinationally as the request is taken.
// A two-entry queue sits between the front end and the point sequencer, so
// new requests are taken while earlier points are still being sent.
// Reset is synchronous and clears the circle state, the queue and the
// output valid. When the receiver holds ready low the current point stays
// in place, the queue fills and then cmd.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_point_generator
  import cmg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cmg_cmd_if.sink  cmd,
  cmg_pt_if.source pts
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t wr_job;
  job_t rd_job;

  // Front end: holds the circle state and turns each request into a job.
  cmg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_full (q_full),
    .push   (push),
    .job    (wr_job)
  );

  // Jobs wait here so either side can stall without holding up the other.
  cmg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  // Back end: walks the mirror codes of a job, one registered point a cycle unless the receiver stalls.
  cmg_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (rd_job),
    .empty (q_empty),
    .pop   (pop),
    .pts   (pts)
  );

endmodule

`default_nettype wire
